FILE: hdl/rcbp_pkg.sv
package rcbp_pkg;

    localparam int ADDR_W             = 12;
    localparam int CONF_W             = 4;
    localparam int REGRET_W           = 3;
    localparam int THR_W              = 4;
    localparam int CFG_DATA_W         = 4;
    localparam int CFG_INDEX_W        = 1;
    localparam int DEFAULT_INDEX_BITS = 12;

    localparam logic signed [CONF_W-1:0] CONF_MAX = 4'sd7;
    localparam logic signed [CONF_W-1:0] CONF_MIN = -4'sd8;

    localparam logic [THR_W-1:0]    THR_RESET   = 4'd4;
    localparam logic [REGRET_W-1:0] LIMIT_RESET = 3'd7;

    // regret penalties for a miss
    localparam logic [REGRET_W:0] MISS_LOW_STEP  = 4'd1;
    localparam logic [REGRET_W:0] MISS_HIGH_STEP = 4'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD    = 1'b0,
        CFG_REGRET_LIMIT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CONF_W-1:0] conf;
        logic [REGRET_W-1:0]      regret;
    } entry_t;

endpackage

FILE: hdl/regret_confidence_branch_predictor.sv
// Channel | Signals                                   | Direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_stall, branch_address,       | branch in
//         | outcome_taken                             |
// out     | out_valid, out_stall, predicted_taken,    | result out
//         | mispredicted                              |
// cfg     | cfg_write, cfg_index, cfg_data            | register write
//
// One resolved branch per cycle sustained while out_stall stays low; the result passes
// through the table read register, then the update stage into the output register.
// The table is one synchronous RAM of 2**INDEX_BITS entries, read on accept and written
// back as the update stage advances; a one-deep bypass covers back-to-back same-index hits.
// After reset a clearing pass zeroes every table entry with in_stall high.
// Configuration writes are taken at any time.
// A stalled output holds its result; the item in the update stage then waits and
// in_stall rises, so nothing is lost.
module regret_confidence_branch_predictor
    import rcbp_pkg::*;
#(
    parameter int INDEX_BITS = DEFAULT_INDEX_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ADDR_W-1:0]      branch_address,
    input  logic                   outcome_taken,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   predicted_taken,
    output logic                   mispredicted,

    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH = 1 << INDEX_BITS;

    // configuration
    logic [THR_W-1:0]    thr_reg;
    logic [REGRET_W-1:0] limit_reg;

    // global history and clearing pass
    logic [INDEX_BITS-1:0] hist_reg;
    logic [INDEX_BITS-1:0] hist_next;
    logic                  clearing_reg;
    logic [INDEX_BITS-1:0] clr_cnt_reg;

    // update stage
    logic                  s1_valid_reg;
    logic [INDEX_BITS-1:0] s1_idx_reg;
    logic                  s1_taken_reg;

    // table RAM and bypass
    entry_t                mem [DEPTH];
    entry_t                rdata_reg;
    logic                  fwd_valid_reg;
    logic [INDEX_BITS-1:0] fwd_idx_reg;
    entry_t                fwd_data_reg;

    // output register
    logic                  out_valid_reg;
    logic                  pred_reg;
    logic                  miss_reg;

    logic                  accept;
    logic                  s1_adv;
    logic [INDEX_BITS-1:0] rd_idx;
    logic                  mem_we;
    logic [INDEX_BITS-1:0] mem_waddr;
    entry_t                mem_wdata;

    entry_t                       cur;
    entry_t                       upd;
    logic signed [CONF_W+1:0]     conf_ext;
    logic signed [CONF_W+1:0]     regret_ext;
    logic signed [CONF_W+1:0]     dv;
    logic [CONF_W-1:0]            mag;
    logic                         pred;
    logic                         miss;
    logic                         high;
    logic [REGRET_W:0]            regret_sum;
    logic signed [CONF_W-1:0]     conf_step;

    // handshake
    assign in_stall = clearing_reg || (s1_valid_reg && out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);

    assign rd_idx    = INDEX_BITS'(branch_address) ^ hist_reg;
    assign hist_next = {hist_reg[INDEX_BITS-2:0], outcome_taken};

    // current entry, with bypass of the write made at the accepting edge
    assign cur = (fwd_valid_reg && fwd_idx_reg == s1_idx_reg) ? fwd_data_reg : rdata_reg;

    always_comb
    begin
        conf_ext   = (CONF_W+2)'(cur.conf);
        regret_ext = $signed({3'b000, cur.regret});
        dv         = cur.conf[CONF_W-1] ? conf_ext + regret_ext : conf_ext - regret_ext;
        pred       = (dv == '0) ? !cur.conf[CONF_W-1] : (dv > 0);
        miss       = pred != s1_taken_reg;
        mag        = cur.conf[CONF_W-1] ? CONF_W'(-conf_ext) : CONF_W'(conf_ext);
        high       = mag >= thr_reg;

        if (s1_taken_reg)
            conf_step = (cur.conf < CONF_MAX) ? cur.conf + 4'sd1 : cur.conf;
        else
            conf_step = (cur.conf > CONF_MIN) ? cur.conf - 4'sd1 : cur.conf;

        regret_sum = {1'b0, cur.regret} + (high ? MISS_HIGH_STEP : MISS_LOW_STEP);
        if (regret_sum > {1'b0, limit_reg})
            regret_sum = {1'b0, limit_reg};

        upd = cur;
        if (!miss)
        begin
            upd.regret = (cur.regret != '0) ? cur.regret - 3'd1 : cur.regret;
            upd.conf   = conf_step;
        end
        else if (high)
        begin
            upd.regret = regret_sum[REGRET_W-1:0];
            upd.conf   = (cur.conf > 4'sd0) ? 4'sd0 : -4'sd1;
        end
        else
        begin
            upd.regret = regret_sum[REGRET_W-1:0];
            upd.conf   = conf_step;
        end
    end

    // RAM write port: clearing pass, else write-back from the update stage
    always_comb
    begin
        mem_we    = clearing_reg || s1_adv;
        mem_waddr = clearing_reg ? clr_cnt_reg : s1_idx_reg;
        mem_wdata = clearing_reg ? entry_t'('0) : upd;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (accept)
            rdata_reg <= mem[rd_idx];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= rd_idx;
            s1_taken_reg <= outcome_taken;
        end
        if (mem_we)
        begin
            fwd_idx_reg  <= mem_waddr;
            fwd_data_reg <= mem_wdata;
        end
        if (s1_adv)
        begin
            pred_reg <= pred;
            miss_reg <= miss;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_RESET;
            limit_reg     <= LIMIT_RESET;
            hist_reg      <= '0;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_THRESHOLD:    thr_reg   <= cfg_data;
                    CFG_REGRET_LIMIT: limit_reg <= cfg_data[REGRET_W-1:0];
                    default:          thr_reg   <= thr_reg;
                endcase
            end

            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == INDEX_BITS'(DEPTH - 1))
                    clearing_reg <= 1'b0;
            end

            if (accept)
                hist_reg <= hist_next;

            if (mem_we)
                fwd_valid_reg <= 1'b1;

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign predicted_taken = pred_reg;
    assign mispredicted    = miss_reg;

    // checks
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !accept)
        else $error("transaction accepted during clearing pass");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(pred_reg) && $stable(miss_reg))
        else $error("stalled result lost or changed");

    a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> hist_reg[0] == $past(outcome_taken))
        else $error("history did not take the outcome");

    a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_idx_reg))
        else $error("update stage item dropped");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the regret-aware confidence branch predictor.
// One process offers resolved branches, a second throttles the result side and
// a third scores every result transaction against a local predictor model.
module tb_top;
    import rcbp_pkg::*;

    localparam int CLK_HALF_NS      = 6;
    localparam int RESET_CYCLES     = 12;
    localparam int DRAIN_CYCLES     = 4;     // pipeline is two stages deep
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int HOT_SLOTS        = 8;
    localparam int TABLE_DEPTH      = 1 << ADDR_W;

    // Expected outcome of one branch: prediction and miss flag.
    typedef struct packed {
        logic predicted;
        logic missed;
    } branch_verdict_t;

    logic                   clk;
    logic                   rst_n          = 1'b0;
    logic                   in_valid       = 1'b0;
    logic                   in_stall;
    logic [ADDR_W-1:0]      branch_address = '0;
    logic                   outcome_taken  = 1'b0;
    logic                   out_valid;
    logic                   out_stall      = 1'b0;
    logic                   predicted_taken;
    logic                   mispredicted;
    logic                   cfg_write      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;

    // Local copy of the predictor state and its two registers.
    logic signed [CONF_W-1:0] conf_mem   [TABLE_DEPTH];
    logic [REGRET_W-1:0]      regret_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]        hist_bits;
    logic [THR_W-1:0]         thr_value;
    logic [REGRET_W-1:0]      limit_value;

    // Predictions waiting for their result transaction, oldest first.
    branch_verdict_t pending_verdicts[$];

    // Working set of table slots that the mixed traffic keeps returning to,
    // each with a preferred direction so that confidence actually builds up.
    logic [ADDR_W-1:0] hot_slot [HOT_SLOTS];
    logic              hot_dir  [HOT_SLOTS];

    bit idling   = 1'b0;
    bit hold_req = 1'b0;

    int sent_count      = 0;
    int checked_count   = 0;
    int miss_count      = 0;
    int high_miss_count = 0;
    int error_count     = 0;

    regret_confidence_branch_predictor i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .branch_address  (branch_address),
        .outcome_taken   (outcome_taken),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .predicted_taken (predicted_taken),
        .mispredicted    (mispredicted),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    // Hard stop, generous enough for the slowest legal run, clearing pass included.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor model
    // ------------------------------------------------------------------

    function automatic int step_conf(int c, logic up);
        if (up)
            return (c < int'(CONF_MAX)) ? c + 1 : c;
        return (c > int'(CONF_MIN)) ? c - 1 : c;
    endfunction

    // Works out prediction and miss flag for one branch, then trains the slot
    // and shifts the outcome into the history.
    function automatic branch_verdict_t resolve_branch(logic [ADDR_W-1:0] addr, logic taken);
        logic [ADDR_W-1:0] slot;
        int                c;
        int                r;
        int                sgn;
        int                dv;
        int                mag;
        logic              guess;
        branch_verdict_t   v;
        slot  = addr ^ hist_bits;
        c     = conf_mem[slot];
        r     = regret_mem[slot];
        sgn   = (c >= 0) ? 1 : -1;
        dv    = c - sgn * r;
        // a zero decision value falls back to the sign of the confidence
        guess = (dv == 0) ? (c >= 0) : (dv > 0);
        mag   = (c < 0) ? -c : c;
        if (guess == taken)
        begin
            if (r > 0)
                r--;
            c = step_conf(c, taken);
        end
        else if (mag >= int'(thr_value))
        begin
            // confident miss: heavier regret, confidence knocked back
            r = (r + 2 > int'(limit_value)) ? int'(limit_value) : r + 2;
            c = (c > 0) ? 0 : -1;
            high_miss_count++;
        end
        else
        begin
            r = (r + 1 > int'(limit_value)) ? int'(limit_value) : r + 1;
            c = step_conf(c, taken);
        end
        conf_mem[slot]   = CONF_W'(c);
        regret_mem[slot] = REGRET_W'(r);
        hist_bits        = {hist_bits[ADDR_W-2:0], taken};
        v.predicted      = guess;
        v.missed         = (guess != taken);
        if (v.missed)
            miss_count++;
        return v;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            conf_mem[i]   = '0;
            regret_mem[i] = '0;
        end
        hist_bits   = '0;
        thr_value   = THR_RESET;
        limit_value = LIMIT_RESET;
    endfunction

    // ------------------------------------------------------------------
    // Branch side
    // ------------------------------------------------------------------

    // Offers one branch and returns on the edge that accepts it. Valid stays
    // high on return so back-to-back transactions need no extra edge.
    task automatic send_branch(logic [ADDR_W-1:0] addr, logic taken);
        int              gap;
        branch_verdict_t verdict;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        branch_address <= addr;
        outcome_taken  <= taken;
        do
            @(posedge clk);
        while (in_stall);
        verdict = resolve_branch(addr, taken);
        pending_verdicts.insert(pending_verdicts.size(), verdict);
        sent_count++;
    endtask

    // Aims a branch at a given table slot by undoing the current history.
    task automatic send_to_slot(logic [ADDR_W-1:0] slot, logic taken);
        send_branch(slot ^ hist_bits, taken);
    endtask

    // Mostly biased traffic on the hot slots, with the odd direction flip and
    // a quarter of fully random branches as noise.
    task automatic send_mixed_item();
        int   k;
        logic taken;
        if ($urandom_range(0, 3) != 0)
        begin
            k = $urandom_range(0, HOT_SLOTS - 1);
            if ($urandom_range(0, 99) == 0)
                hot_dir[k] = ~hot_dir[k];
            taken = ($urandom_range(0, 7) == 0) ? ~hot_dir[k] : hot_dir[k];
            send_to_slot(hot_slot[k], taken);
        end
        else
        begin
            send_branch(ADDR_W'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_mixed_traffic(int count, bit with_idling);
        for (int n = 0; n < count; n++)
        begin
            // idle-free stretches now and then, even when idling is allowed
            if (n % 64 == 0)
                idling = with_idling && ($urandom_range(0, 3) != 0);
            send_mixed_item();
        end
    endtask

    // Drops valid, waits for every outstanding result, then lets the pipe empty.
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; only issued while the block is idle.
    task automatic write_register(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        case (which)
            CFG_THRESHOLD:    thr_value   = value;
            CFG_REGRET_LIMIT: limit_value = value[REGRET_W-1:0];
            default:          ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Random stall bursts, plus one long hold-off on request so that the
    // block backs up and raises in_stall while branches keep coming.
    initial
    begin : receiver_stall
        int burst;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (burst - 1) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        branch_verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result transaction with no branch outstanding");
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (predicted_taken !== want.predicted)
                begin
                    $error("predicted_taken: expected %0b, actual %0b",
                           want.predicted, predicted_taken);
                    error_count++;
                end
                if (mispredicted !== want.missed)
                begin
                    $error("mispredicted: expected %0b, actual %0b",
                           want.missed, mispredicted);
                    error_count++;
                end
                checked_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Address extremes and alternating patterns, both outcomes, reset settings.
    task automatic test_field_extremes();
        idling = 1'b0;
        send_branch('0, 1'b0);
        send_branch('0, 1'b1);
        send_branch('1, 1'b0);
        send_branch('1, 1'b1);
        send_branch(12'hAAA, 1'b1);
        send_branch(12'h555, 1'b0);
        send_branch(12'hAAA, 1'b0);
        send_branch(12'h555, 1'b1);
        finish_phase();
    endtask

    // Back-to-back transactions on one slot: saturate at +7, take a confident
    // miss, then walk through a zero decision value on the negative side.
    task automatic test_slot_training();
        idling = 1'b0;
        repeat (9) send_to_slot(12'h5A5, 1'b1);
        send_to_slot(12'h5A5, 1'b0);
        send_to_slot(12'h5A5, 1'b0);
        send_to_slot(12'h5A5, 1'b0);
        send_to_slot(12'h5A5, 1'b1);
        finish_phase();
    endtask

    task automatic test_reset_settings_mix();
        run_mixed_traffic(480, 1'b1);
        finish_phase();
    endtask

    // Threshold zero: every miss is confident. Limit zero: a miss sets the regret to 0.
    task automatic test_every_miss_confident();
        write_register(CFG_THRESHOLD, 4'd0);
        write_register(CFG_REGRET_LIMIT, 4'd0);
        run_mixed_traffic(250, 1'b1);
        finish_phase();
    endtask

    // Threshold eight: only a confidence of -8 qualifies. Regret builds to 7.
    task automatic test_threshold_top();
        write_register(CFG_THRESHOLD, 4'd8);
        write_register(CFG_REGRET_LIMIT, 4'd7);
        run_mixed_traffic(250, 1'b1);
        finish_phase();
    endtask

    // Threshold out of reach; limit lowered below regrets already stored.
    task automatic test_threshold_unreachable();
        write_register(CFG_THRESHOLD, 4'd15);
        write_register(CFG_REGRET_LIMIT, 4'd3);
        run_mixed_traffic(250, 1'b1);
        finish_phase();
    endtask

    // Long hold-off on the result side while branches keep streaming in.
    task automatic test_output_backpressure();
        write_register(CFG_THRESHOLD, 4'd2);
        write_register(CFG_REGRET_LIMIT, 4'd5);
        idling   = 1'b0;
        hold_req = 1'b1;
        repeat (150) send_mixed_item();
        finish_phase();
    endtask

    // Back at reset values, full rate with no idling on either side.
    task automatic test_steady_stream();
        write_register(CFG_THRESHOLD, THR_RESET);
        write_register(CFG_REGRET_LIMIT, CFG_DATA_W'(LIMIT_RESET));
        run_mixed_traffic(450, 1'b0);
        finish_phase();
    endtask

    initial
    begin
        clear_model();
        for (int k = 0; k < HOT_SLOTS; k++)
        begin
            hot_slot[k] = ADDR_W'($urandom);
            hot_dir[k]  = k[0];
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the clearing pass holds in_stall high; the first send just waits
        test_field_extremes();
        test_slot_training();
        test_reset_settings_mix();
        test_every_miss_confident();
        test_threshold_top();
        test_threshold_unreachable();
        test_output_backpressure();
        test_steady_stream();

        $display("Ran %0d branches under five register settings, incl. a long output hold-off.",
                 sent_count);
        $display("Checked %0d results: %0d mispredictions, %0d of them confident misses.",
                 checked_count, miss_count, high_miss_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/rcbp_pkg.sv
hdl/regret_confidence_branch_predictor.sv
verif/tb_top.sv
